// File: design/smf_pkg.sv
// shared types, constants and helpers for the smoothing filter with change mark
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package smf_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int PIXEL_BITS = 8;
  localparam int MIN_SIZE   = 3;
  localparam int RING_ROWS  = 5;
  localparam int WIN        = 5;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = 8;
  localparam int BANK_BITS = $clog2(RING_ROWS);
  localparam int LAG_BITS  = ROW_BITS + 1;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  // sum widths
  localparam int SUM_BITS  = 13;
  localparam int ROW5_BITS = 11;
  localparam int ROW3_BITS = 10;

  // truncating division by a reciprocal, exact over the sum range
  localparam int RECIP25  = 5243;
  localparam int SHIFT25  = 17;
  localparam int RECIP9   = 3641;
  localparam int SHIFT9   = 15;
  localparam int SHIFT16  = 4;
  localparam int PROD_BITS = 2 * SUM_BITS;

  // register indexes
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  // filter modes
  localparam logic [1:0] MODE_BOX3  = 2'd0;
  localparam logic [1:0] MODE_BOX5  = 2'd1;
  localparam logic [1:0] MODE_GAUSS = 2'd2;

  localparam logic [7:0] RESET_WIDTH     = 8'd80;
  localparam logic [7:0] RESET_HEIGHT    = 8'd40;
  localparam logic [7:0] RESET_THRESHOLD = 8'd10;

  typedef struct packed {
    logic [1:0]            mode;
    logic [PIXEL_BITS-1:0] thresh;
  } cfg_t;

  typedef struct packed {
    logic                  shift;
    logic [PIXEL_BITS-1:0] pix;
    logic [BANK_BITS-1:0]  wbank;
    logic [COL_BITS-1:0]   wcol;
    logic                  emit;
    logic [BANK_BITS-1:0]  obank;
    logic [COL_BITS-1:0]   ocol;
    logic                  border;
    logic                  last;
  } cmd_t;

  typedef struct packed {
    logic                  emit;
    logic                  border;
    logic                  last;
    logic [PIXEL_BITS-1:0] orig;
  } stage_t;

  // ring bank holding the row j above the row in bank b
  function automatic logic [BANK_BITS-1:0] bank_sub(input logic [BANK_BITS-1:0] b,
                                                    input logic [BANK_BITS-1:0] j);
    logic [BANK_BITS:0] t;
    t = {1'b0, b} + (BANK_BITS+1)'(RING_ROWS) - {1'b0, j};
    if (t >= (BANK_BITS+1)'(RING_ROWS)) begin
      t = t - (BANK_BITS+1)'(RING_ROWS);
    end
    return t[BANK_BITS-1:0];
  endfunction

endpackage

// File: design/smf_front.sv
// front end: configuration registers, raster counters and item classification
// depends on smf_pkg; pushes one command per useful word into the queue
`timescale 1ns / 1ps

module smf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [smf_pkg::PIXEL_BITS-1:0] pixel_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          q_full,
  output logic                          q_push,
  output smf_pkg::cmd_t                 q_cmd,
  output smf_pkg::cfg_t                 cfg
);

  logic [1:0] filter_mode;
  logic [7:0] image_width;
  logic [7:0] image_height;
  logic [7:0] diff_threshold;

  logic [smf_pkg::ROW_BITS-1:0]  in_row, in_row_next, out_row, out_row_next;
  logic [smf_pkg::COL_BITS-1:0]  in_col, in_col_next, out_col, out_col_next;
  logic [smf_pkg::BANK_BITS-1:0] in_bank, in_bank_next, out_bank, out_bank_next;
  logic [smf_pkg::LAG_BITS-1:0]  pend, pend_next;

  logic [7:0]                    w, h;
  logic                          rad2;
  logic [smf_pkg::LAG_BITS-1:0]  lag, rad;
  logic [smf_pkg::LAG_BITS-1:0]  r9, c9;
  logic                          do_write, do_emit, do_clear, fire, cfg_fire;
  logic                          border, last;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign in_ready  = !q_full;
  assign fire      = in_valid && in_ready;
  assign cfg.mode   = filter_mode;
  assign cfg.thresh = diff_threshold;

  always_comb begin
    w = image_width;
    if (image_width < 8'(smf_pkg::MIN_SIZE)) begin
      w = 8'(smf_pkg::MIN_SIZE);
    end else if (image_width > 8'(smf_pkg::MAX_WIDTH)) begin
      w = 8'(smf_pkg::MAX_WIDTH);
    end
    h = image_height;
    if (image_height < 8'(smf_pkg::MIN_SIZE)) begin
      h = 8'(smf_pkg::MIN_SIZE);
    end else if (image_height > 8'(smf_pkg::MAX_HEIGHT)) begin
      h = 8'(smf_pkg::MAX_HEIGHT);
    end
    rad2 = (filter_mode == smf_pkg::MODE_BOX5);
    rad  = rad2 ? 9'd2 : 9'd1;
    lag  = rad2 ? ({w, 1'b0} + 9'd2) : ({1'b0, w} + 9'd1);

    r9 = {1'b0, out_row};
    c9 = {2'b00, out_col};
    border = (r9 < rad) || (c9 < rad) || (r9 + rad >= {1'b0, h}) || (c9 + rad >= {1'b0, w});
    last   = (out_row == h - 8'd1) && ({1'b0, out_col} == w - 8'd1);

    do_write = 1'b0;
    do_emit  = 1'b0;
    do_clear = 1'b0;
    // once the frame is in, any word drains one pending result
    if (in_row >= h) begin
      if (out_row < h) begin
        do_emit = 1'b1;
      end else begin
        do_clear = 1'b1;
      end
    end else if (!kind) begin
      do_write = 1'b1;
      if (pend >= lag) begin
        do_emit = 1'b1;
      end
    end
  end

  always_comb begin
    q_cmd.shift  = do_write;
    q_cmd.pix    = pixel_value;
    q_cmd.wbank  = in_bank;
    q_cmd.wcol   = in_col;
    q_cmd.emit   = do_emit;
    q_cmd.obank  = out_bank;
    q_cmd.ocol   = out_col;
    q_cmd.border = border;
    q_cmd.last   = last;
    q_push = fire && (do_write || do_emit);
  end

  always_comb begin
    in_row_next   = in_row;
    in_col_next   = in_col;
    in_bank_next  = in_bank;
    out_row_next  = out_row;
    out_col_next  = out_col;
    out_bank_next = out_bank;
    pend_next     = pend;
    if (do_write) begin
      pend_next = pend + 9'd1;
      if ({1'b0, in_col} + 8'd1 >= w) begin
        in_col_next = '0;
        in_row_next = in_row + 8'd1;
        in_bank_next = (in_bank == 3'(smf_pkg::RING_ROWS - 1)) ? '0 : in_bank + 3'd1;
      end else begin
        in_col_next = in_col + 7'd1;
      end
    end
    if (do_emit) begin
      pend_next = do_write ? pend : pend - 9'd1;
      if ({1'b0, out_col} + 8'd1 >= w) begin
        out_col_next = '0;
        out_row_next = out_row + 8'd1;
        out_bank_next = (out_bank == 3'(smf_pkg::RING_ROWS - 1)) ? '0 : out_bank + 3'd1;
      end else begin
        out_col_next = out_col + 7'd1;
      end
    end
    if (do_clear || (do_emit && last)) begin
      in_row_next   = '0;
      in_col_next   = '0;
      in_bank_next  = '0;
      out_row_next  = '0;
      out_col_next  = '0;
      out_bank_next = '0;
      pend_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode    <= smf_pkg::MODE_BOX3;
      image_width    <= smf_pkg::RESET_WIDTH;
      image_height   <= smf_pkg::RESET_HEIGHT;
      diff_threshold <= smf_pkg::RESET_THRESHOLD;
      in_row   <= '0;
      in_col   <= '0;
      in_bank  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_bank <= '0;
      pend     <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        smf_pkg::REG_MODE:      filter_mode    <= cfg_data[1:0];
        smf_pkg::REG_WIDTH:     image_width    <= cfg_data;
        smf_pkg::REG_HEIGHT:    image_height   <= cfg_data;
        smf_pkg::REG_THRESHOLD: diff_threshold <= cfg_data;
        default:                diff_threshold <= diff_threshold;
      endcase
      // any write restarts the frame
      in_row   <= '0;
      in_col   <= '0;
      in_bank  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_bank <= '0;
      pend     <= '0;
    end else if (fire) begin
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      in_bank  <= in_bank_next;
      out_row  <= out_row_next;
      out_col  <= out_col_next;
      out_bank <= out_bank_next;
      pend     <= pend_next;
    end
  end

endmodule

// File: design/smf_fifo.sv
// short command queue between the front end and the filter datapath
// depends on smf_pkg for the command type and depth
`timescale 1ns / 1ps

module smf_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  smf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output smf_pkg::cmd_t pop_cmd
);

  smf_pkg::cmd_t entries [smf_pkg::FIFO_DEPTH];
  logic [smf_pkg::FIFO_PTR_BITS-1:0] wptr, rptr;
  logic [smf_pkg::FIFO_PTR_BITS:0]   count;

  assign full    = (count == (smf_pkg::FIFO_PTR_BITS+1)'(smf_pkg::FIFO_DEPTH));
  assign valid   = (count != '0);
  assign pop_cmd = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (smf_pkg::FIFO_PTR_BITS+1)'(push) - (smf_pkg::FIFO_PTR_BITS+1)'(pop);
    end
  end

endmodule

// File: design/smf_back.sv
// filter datapath: line buffer ring, 5x5 window, sums, division and change mark
// depends on smf_pkg; takes commands from the queue, drives the output register
`timescale 1ns / 1ps

module smf_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  smf_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  input  smf_pkg::cfg_t                  cfg,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [smf_pkg::PIXEL_BITS-1:0] smoothed_value,
  output logic                           change_mark,
  output logic                           frame_last
);

  localparam int W = smf_pkg::WIN;

  logic [smf_pkg::PIXEL_BITS-1:0] line_mem [smf_pkg::RING_ROWS][smf_pkg::MAX_WIDTH];
  logic [smf_pkg::PIXEL_BITS-1:0] rda [smf_pkg::RING_ROWS];
  logic [smf_pkg::PIXEL_BITS-1:0] rdb [smf_pkg::RING_ROWS];

  // win[j][k]: j rows up, k columns back from the newest pixel
  logic [smf_pkg::PIXEL_BITS-1:0] win [W][W];
  logic [smf_pkg::PIXEL_BITS-1:0] col_in [W];

  logic adv;
  logic v1, v2, v3, v4, v5;
  smf_pkg::cmd_t   c1;
  smf_pkg::stage_t s2, s3, s4, s5;

  logic [smf_pkg::ROW5_BITS-1:0] rs5_c [W];
  logic [smf_pkg::ROW3_BITS-1:0] rs3_c [3];
  logic [smf_pkg::ROW3_BITS-1:0] rg_c  [3];
  logic [smf_pkg::ROW5_BITS-1:0] rs5 [W];
  logic [smf_pkg::ROW3_BITS-1:0] rs3 [3];
  logic [smf_pkg::ROW3_BITS-1:0] rg  [3];

  logic [smf_pkg::SUM_BITS-1:0]  sum_c, sum4;
  logic [smf_pkg::SUM_BITS-1:0]  recip;
  logic [smf_pkg::PROD_BITS-1:0] prod;
  logic [smf_pkg::PIXEL_BITS-1:0] q_c, q5, sm;
  logic is_box5, is_gauss;

  assign adv      = !out_valid || out_ready;
  assign q_pop    = adv && q_valid;
  assign is_box5  = (cfg.mode == smf_pkg::MODE_BOX5);
  assign is_gauss = (cfg.mode == smf_pkg::MODE_GAUSS);

  // line buffers: one write and two reads per bank
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_cmd.shift) begin
        line_mem[q_cmd.wbank][q_cmd.wcol] <= q_cmd.pix;
      end
      for (int b = 0; b < smf_pkg::RING_ROWS; b++) begin
        rda[b] <= line_mem[b][q_cmd.wcol];
        rdb[b] <= line_mem[b][q_cmd.ocol];
      end
    end
  end

  always_comb begin
    col_in[0] = c1.pix;
    for (int j = 1; j < W; j++) begin
      col_in[j] = rda[smf_pkg::bank_sub(c1.wbank, 3'(j))];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1 && c1.shift) begin
      for (int j = 0; j < W; j++) begin
        win[j][0] <= col_in[j];
        for (int k = 1; k < W; k++) begin
          win[j][k] <= win[j][k-1];
        end
      end
    end
  end

  // row sums; gaussian weights 1-2-1 along a row
  always_comb begin
    for (int j = 0; j < W; j++) begin
      rs5_c[j] = '0;
      for (int k = 0; k < W; k++) begin
        rs5_c[j] = rs5_c[j] + 11'(win[j][k]);
      end
    end
    for (int j = 0; j < 3; j++) begin
      rs3_c[j] = 10'(win[j][0]) + 10'(win[j][1]) + 10'(win[j][2]);
      rg_c[j]  = 10'(win[j][0]) + {1'b0, win[j][1], 1'b0} + 10'(win[j][2]);
    end
  end

  always_comb begin
    if (is_box5) begin
      sum_c = 13'(rs5[0]) + 13'(rs5[1]) + 13'(rs5[2]) + 13'(rs5[3]) + 13'(rs5[4]);
    end else if (is_gauss) begin
      sum_c = 13'(rg[0]) + {2'b00, rg[1], 1'b0} + 13'(rg[2]);
    end else begin
      sum_c = 13'(rs3[0]) + 13'(rs3[1]) + 13'(rs3[2]);
    end
  end

  always_comb begin
    recip = is_box5 ? 13'(smf_pkg::RECIP25) : 13'(smf_pkg::RECIP9);
    prod  = 26'(sum4) * 26'(recip);
    if (is_gauss) begin
      q_c = 8'(sum4 >> smf_pkg::SHIFT16);
    end else if (is_box5) begin
      q_c = 8'(prod >> smf_pkg::SHIFT25);
    end else begin
      q_c = 8'(prod >> smf_pkg::SHIFT9);
    end
  end

  assign sm = s5.border ? s5.orig : q5;

  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= q_cmd;
      s2.emit   <= c1.emit;
      s2.border <= c1.border;
      s2.last   <= c1.last;
      s2.orig   <= rdb[c1.obank];
      s3 <= s2;
      for (int j = 0; j < W; j++) begin
        rs5[j] <= rs5_c[j];
      end
      for (int j = 0; j < 3; j++) begin
        rs3[j] <= rs3_c[j];
        rg[j]  <= rg_c[j];
      end
      s4   <= s3;
      sum4 <= sum_c;
      s5   <= s4;
      q5   <= q_c;
      smoothed_value <= sm;
      change_mark    <= (s5.orig > sm) && ((s5.orig - sm) > cfg.thresh);
      frame_last     <= s5.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5 && s5.emit;
    end
  end

endmodule

// File: design/smoothing_filter_change_mask_top.sv
// top level of the smoothing filter with change mark
// depends on smf_pkg, smf_front, smf_fifo and smf_back
`timescale 1ns / 1ps

// Smooths an 8-bit raster frame by a 3x3 mean, a 5x5 mean or a 3x3 1-2-1 gaussian,
// chosen by filter_mode; border pixels pass unchanged, and each result carries a
// change mark (original minus smoothed above diff_threshold) and tlast on the
// frame's last pixel. One word is taken every clock while the output is drained;
// the result of a pixel appears after the pixel R rows and R columns further on
// (R = 2 in 5x5 mode, else 1) has been taken and has passed through the window
// and divide pipeline. The last R*width+R results of a frame are pushed out by
// words of either kind taken after the frame, one per word. A ring of five 128-pixel line
// buffers, each with one write and two read ports, feeds a 5x5 window; line
// buffer contents need no clearing after reset. Any configuration write restarts
// the frame and must be made while the block is idle.

module smoothing_filter_change_mask_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel_value
  input  logic       s_axis_tuser,   // [0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] smoothed_value
  output logic       m_axis_tuser,   // [0] change_mark
  output logic       m_axis_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  smf_pkg::cmd_t push_cmd, pop_cmd;
  smf_pkg::cfg_t cfg;
  logic          push, pop, full, q_valid;

  smf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .kind        (s_axis_tuser),
    .pixel_value (s_axis_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (full),
    .q_push      (push),
    .q_cmd       (push_cmd),
    .cfg         (cfg)
  );

  smf_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  smf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (pop_cmd),
    .q_pop          (pop),
    .cfg            (cfg),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .smoothed_value (m_axis_tdata),
    .change_mark    (m_axis_tuser),
    .frame_last     (m_axis_tlast)
  );

endmodule
